/* rtl/icr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package icr_pkg;

    localparam int IRQ_COUNT   = 64;
    localparam int IRQ_IDX_W   = $clog2(IRQ_COUNT);
    localparam int PRIO_ROWS   = (IRQ_COUNT + 3) / 4;
    localparam int PRIO_ROW_W  = $clog2(PRIO_ROWS);
    localparam int PRIO_LANES  = 4;

    localparam int OFFSET_W    = 12;
    localparam int WORD_W      = 4;
    localparam int PRIO_IDX_W  = 9;
    localparam int PRIO_Q_W    = 10;
    localparam int CFG_W       = 4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [OFFSET_W-1:0] OFF_SET_EN     = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_CLR_EN     = 12'h080;
    localparam logic [OFFSET_W-1:0] OFF_SET_PEND   = 12'h100;
    localparam logic [OFFSET_W-1:0] OFF_CLR_PEND   = 12'h180;
    localparam logic [OFFSET_W-1:0] OFF_PRIO_FIRST = 12'h300;
    localparam logic [OFFSET_W-1:0] OFF_PRIO_END   = 12'h4F0;

    localparam logic [CFG_W-1:0] PRIO_BITS_RESET = 4'd3;
    localparam logic [CFG_W-1:0] PRIO_BITS_MIN   = 4'd3;
    localparam logic [CFG_W-1:0] PRIO_BITS_MAX   = 4'd8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_UNHANDLED = 2'd2
    } icr_status_t;

    typedef enum logic [2:0] {
        REGION_SET_EN,
        REGION_CLR_EN,
        REGION_SET_PEND,
        REGION_CLR_PEND,
        REGION_PRIO,
        REGION_NONE
    } icr_region_t;

    typedef struct packed {
        icr_region_t             region;
        icr_status_t             status;
        logic [WORD_W-1:0]       word;
        logic [PRIO_IDX_W-1:0]   base;
    } icr_dec_t;

    function automatic icr_dec_t icr_decode(input logic [OFFSET_W-1:0] offset,
                                            input logic [1:0] size);
        icr_dec_t dec;
        dec.region = REGION_NONE;
        dec.status = ST_OK;
        dec.word   = offset[5:2];
        dec.base   = PRIO_IDX_W'(offset - OFF_PRIO_FIRST);
        if (offset[11:6] == OFF_SET_EN[11:6]) begin
            dec.region = REGION_SET_EN;
        end else if (offset[11:6] == OFF_CLR_EN[11:6]) begin
            dec.region = REGION_CLR_EN;
        end else if (offset[11:6] == OFF_SET_PEND[11:6]) begin
            dec.region = REGION_SET_PEND;
        end else if (offset[11:6] == OFF_CLR_PEND[11:6]) begin
            dec.region = REGION_CLR_PEND;
        end else if (offset >= OFF_PRIO_FIRST && offset < OFF_PRIO_END) begin
            dec.region = REGION_PRIO;
        end
        case (dec.region)
            REGION_SET_EN, REGION_CLR_EN, REGION_SET_PEND, REGION_CLR_PEND: begin
                if (size != SIZE_WORD) begin
                    dec.status = ST_BAD_SIZE;
                end
            end
            REGION_PRIO: begin
                if (size != SIZE_BYTE && size != SIZE_WORD) begin
                    dec.status = ST_BAD_SIZE;
                end
            end
            default: begin
                dec.status = ST_UNHANDLED;
            end
        endcase
        return dec;
    endfunction

endpackage

`default_nettype wire

/* rtl/icr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module icr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/interrupt_controller_registers.sv */
`timescale 1ns / 1ps
`default_nettype none

// Register file of a nested vectored interrupt controller: one bus access per beat in, one
// result beat (read data and status) out. Set/clear-enable words at 0x000/0x080, set/clear-
// pending words at 0x100/0x180 (word access only), priority bytes at 0x300-0x4EF (byte or
// unaligned word access, little-endian, only the configured number of top priority bits
// kept; the width used is clamped to 3..8). Status 0 is ok, 1 a wrong access size, 2 an
// unmapped offset; read data is zero for writes and for any error. A beat can be accepted
// every cycle while results are taken. Its result goes through the input stage register into
// the output register; the input stage also does the registered read of the four priority
// RAM banks (one per byte lane), and the output register takes the result formed from it.
// State changes commit at acceptance. Reset clears all enable and pending bits and marks all
// priority bytes zero through per-interrupt valid bits, so no clearing pass is needed.
module interrupt_controller_registers
    import icr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic [1:0]          s_access_size,
    input  wire logic [OFFSET_W-1:0] s_reg_offset,
    input  wire logic [31:0]         s_write_data,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              m_read_data,
    output logic [1:0]               m_status
);

    logic                  s_acc;
    logic                  s1_adv;
    logic                  wr_ok;
    icr_dec_t              in_dec;

    logic [CFG_W-1:0]      prio_width_reg, prio_width_next;
    logic [CFG_W-1:0]      prio_bits_clamped;
    logic [7:0]            prio_mask;

    logic [IRQ_COUNT-1:0]  irq_enabled_reg, irq_enabled_next;
    logic [IRQ_COUNT-1:0]  irq_pending_reg, irq_pending_next;
    logic [IRQ_COUNT-1:0]  prio_valid_reg, prio_valid_next;

    logic [1:0]            bank_lane [PRIO_LANES];
    logic [PRIO_Q_W-1:0]   bank_q    [PRIO_LANES];
    logic [PRIO_LANES-1:0] bank_we;
    logic [PRIO_ROW_W-1:0] bank_addr [PRIO_LANES];
    logic [7:0]            bank_wdata [PRIO_LANES];
    logic [7:0]            bank_rdata [PRIO_LANES];

    logic [PRIO_Q_W-1:0]   lane_q [PRIO_LANES];
    logic [PRIO_LANES-1:0] lane_ok;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_op_reg, s1_op_next;
    icr_dec_t              s1_dec_reg, s1_dec_next;
    logic [PRIO_LANES-1:0] s1_lane_ok_reg, s1_lane_ok_next;
    logic [1:0]            s1_base_reg, s1_base_next;

    logic [31:0]           en_word;
    logic [31:0]           pend_word;
    logic [31:0]           prio_word;
    logic [31:0]           read_value;

    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           m_read_data_reg, m_read_data_next;
    icr_status_t           m_status_reg, m_status_next;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || !m_valid_reg || m_ready;
    assign s_acc   = s_valid && s_ready;
    assign in_dec  = icr_decode(s_reg_offset, s_access_size);
    assign wr_ok   = s_acc && (s_op == OP_WRITE) && (in_dec.status == ST_OK);

    always_comb begin
        prio_width_next = cfg_wr_en ? cfg_wr_data : prio_width_reg;
        if (prio_width_reg < PRIO_BITS_MIN) begin
            prio_bits_clamped = PRIO_BITS_MIN;
        end else if (prio_width_reg > PRIO_BITS_MAX) begin
            prio_bits_clamped = PRIO_BITS_MAX;
        end else begin
            prio_bits_clamped = prio_width_reg;
        end
        prio_mask = 8'hFF << (PRIO_BITS_MAX - prio_bits_clamped);
    end

    // set/clear-enable and set/clear-pending writes
    always_comb begin
        irq_enabled_next = irq_enabled_reg;
        irq_pending_next = irq_pending_reg;
        for (int i = 0; i < IRQ_COUNT; i++) begin
            if (wr_ok && in_dec.word == WORD_W'(i >> 5) && s_write_data[i % 32]) begin
                case (in_dec.region)
                    REGION_SET_EN:   irq_enabled_next[i] = 1'b1;
                    REGION_CLR_EN:   irq_enabled_next[i] = 1'b0;
                    REGION_SET_PEND: irq_pending_next[i] = 1'b1;
                    REGION_CLR_PEND: irq_pending_next[i] = 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // priority banks: bank b holds interrupts with index mod 4 == b
    always_comb begin
        prio_valid_next = prio_valid_reg;
        for (int b = 0; b < PRIO_LANES; b++) begin
            bank_lane[b]  = 2'(b) - in_dec.base[1:0];
            bank_q[b]     = PRIO_Q_W'(in_dec.base) + PRIO_Q_W'(bank_lane[b]);
            bank_we[b]    = wr_ok && (in_dec.region == REGION_PRIO)
                            && (bank_lane[b] == 2'd0 || s_access_size == SIZE_WORD)
                            && (bank_q[b] < PRIO_Q_W'(IRQ_COUNT));
            bank_addr[b]  = bank_q[b][PRIO_ROW_W+1:2];
            bank_wdata[b] = s_write_data[{bank_lane[b], 3'b000} +: 8] & prio_mask;
            if (bank_we[b]) begin
                prio_valid_next[bank_q[b][IRQ_IDX_W-1:0]] = 1'b1;
            end
        end
        for (int k = 0; k < PRIO_LANES; k++) begin
            lane_q[k]  = PRIO_Q_W'(in_dec.base) + PRIO_Q_W'(k);
            lane_ok[k] = (in_dec.region == REGION_PRIO)
                         && (k == 0 || s_access_size == SIZE_WORD)
                         && (lane_q[k] < PRIO_Q_W'(IRQ_COUNT))
                         && prio_valid_reg[lane_q[k][IRQ_IDX_W-1:0]];
        end
    end

    for (genvar b = 0; b < PRIO_LANES; b++) begin : g_bank
        icr_ram #(
            .WIDTH (8),
            .DEPTH (PRIO_ROWS)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (bank_we[b]),
            .wr_addr (bank_addr[b]),
            .wr_data (bank_wdata[b]),
            .rd_en   (s_acc),
            .rd_addr (bank_addr[b]),
            .rd_data (bank_rdata[b])
        );
    end

    // input stage
    always_comb begin
        s1_valid_next   = s_acc || (s1_valid_reg && !s1_adv);
        s1_op_next      = s1_op_reg;
        s1_dec_next     = s1_dec_reg;
        s1_lane_ok_next = s1_lane_ok_reg;
        s1_base_next    = s1_base_reg;
        if (s_acc) begin
            s1_op_next      = s_op;
            s1_dec_next     = in_dec;
            s1_lane_ok_next = lane_ok;
            s1_base_next    = in_dec.base[1:0];
        end
    end

    // result stage
    always_comb begin
        en_word   = '0;
        pend_word = '0;
        prio_word = '0;
        for (int i = 0; i < IRQ_COUNT; i++) begin
            if (s1_dec_reg.word == WORD_W'(i >> 5)) begin
                en_word[i % 32]   = irq_enabled_reg[i];
                pend_word[i % 32] = irq_pending_reg[i];
            end
        end
        for (int k = 0; k < PRIO_LANES; k++) begin
            if (s1_lane_ok_reg[k]) begin
                prio_word[8*k +: 8] = bank_rdata[2'(s1_base_reg + 2'(k))];
            end
        end
        case (s1_dec_reg.region)
            REGION_SET_EN, REGION_CLR_EN:     read_value = en_word;
            REGION_SET_PEND, REGION_CLR_PEND: read_value = pend_word;
            REGION_PRIO:                      read_value = prio_word;
            default:                          read_value = '0;
        endcase

        m_valid_next     = s1_adv || (m_valid_reg && !m_ready);
        m_read_data_next = m_read_data_reg;
        m_status_next    = m_status_reg;
        if (s1_adv) begin
            m_status_next    = s1_dec_reg.status;
            m_read_data_next = (s1_op_reg == OP_READ && s1_dec_reg.status == ST_OK)
                               ? read_value : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_width_reg  <= PRIO_BITS_RESET;
            irq_enabled_reg <= '0;
            irq_pending_reg <= '0;
            prio_valid_reg  <= '0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            prio_width_reg  <= prio_width_next;
            irq_enabled_reg <= irq_enabled_next;
            irq_pending_reg <= irq_pending_next;
            prio_valid_reg  <= prio_valid_next;
            s1_valid_reg    <= s1_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg       <= s1_op_next;
        s1_dec_reg      <= s1_dec_next;
        s1_lane_ok_reg  <= s1_lane_ok_next;
        s1_base_reg     <= s1_base_next;
        m_read_data_reg <= m_read_data_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

`ifndef SYNTHESIS
    a_err_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_read_data == '0))
        else $error("error beat carries nonzero read data");

    a_write_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_op_reg == OP_WRITE) |=> (m_read_data == '0))
        else $error("write beat produced nonzero read data");

    a_err_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && in_dec.status != ST_OK)
        |=> ($stable(irq_enabled_reg) && $stable(irq_pending_reg)
             && $stable(prio_valid_reg)))
        else $error("rejected access changed state");

    a_idle_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=> ($stable(irq_enabled_reg) && $stable(irq_pending_reg)))
        else $error("enable or pending bits changed without an accepted beat");
`endif

endmodule

`default_nettype wire

/* tb/interrupt_controller_registers_tb.sv */
`timescale 1ns / 1ps

module interrupt_controller_registers_tb;
    import icr_pkg::*;

    localparam logic [1:0]          SIZE_RSVD = 2'd3;
    localparam logic [OFFSET_W-1:0] WORD_SPAN = 12'h040;
    localparam int                  PHASES    = 6;
    localparam int                  PHASE_LEN = 160;

    typedef struct packed {
        logic                op;
        logic [1:0]          size;
        logic [OFFSET_W-1:0] offset;
        logic [31:0]         data;
    } bus_access_t;

    typedef struct packed {
        logic [31:0] read_data;
        icr_status_t status;
    } access_result_t;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data   = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_op          = OP_READ;
    logic [1:0]          s_access_size = SIZE_BYTE;
    logic [OFFSET_W-1:0] s_reg_offset  = '0;
    logic [31:0]         s_write_data  = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [31:0]         m_read_data;
    logic [1:0]          m_status;

    bus_access_t    access_q[$];
    access_result_t response_q[$];
    bus_access_t    beat_on_bus;
    access_result_t head_resp;
    int unsigned    outstanding = 0;
    int unsigned    mismatches  = 0;
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;

    bit             irq_en  [IRQ_COUNT];
    bit             irq_pend[IRQ_COUNT];
    bit [7:0]       irq_prio[IRQ_COUNT];
    logic [CFG_W-1:0] prio_bits_cfg = PRIO_BITS_RESET;

    interrupt_controller_registers dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_access_size (s_access_size),
        .s_reg_offset  (s_reg_offset),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic access_result_t apply_register_access(bus_access_t a);
        access_result_t   r;
        icr_region_t      region;
        logic [31:0]      rd;
        logic [7:0]       mask;
        int unsigned      first;
        int unsigned      idx;
        logic [CFG_W-1:0] bits;
        int unsigned      lanes;
        rd       = '0;
        r.status = ST_OK;
        if (a.offset < OFF_SET_EN + WORD_SPAN) begin
            region = REGION_SET_EN;
        end else if (a.offset >= OFF_CLR_EN && a.offset < OFF_CLR_EN + WORD_SPAN) begin
            region = REGION_CLR_EN;
        end else if (a.offset >= OFF_SET_PEND && a.offset < OFF_SET_PEND + WORD_SPAN) begin
            region = REGION_SET_PEND;
        end else if (a.offset >= OFF_CLR_PEND && a.offset < OFF_CLR_PEND + WORD_SPAN) begin
            region = REGION_CLR_PEND;
        end else if (a.offset >= OFF_PRIO_FIRST && a.offset < OFF_PRIO_END) begin
            region = REGION_PRIO;
        end else begin
            region = REGION_NONE;
        end
        case (region)
            REGION_SET_EN, REGION_CLR_EN, REGION_SET_PEND, REGION_CLR_PEND: begin
                if (a.size != SIZE_WORD) begin
                    r.status = ST_BAD_SIZE;
                end else begin
                    first = 32 * a.offset[5:2];
                    for (int i = 0; i < 32; i++) begin
                        idx = first + i;
                        if (idx < IRQ_COUNT) begin
                            if (a.op == OP_READ) begin
                                rd[i] = (region == REGION_SET_EN || region == REGION_CLR_EN) ?
                                        irq_en[idx] : irq_pend[idx];
                            end else if (a.data[i]) begin
                                case (region)
                                    REGION_SET_EN:   irq_en[idx]   = 1'b1;
                                    REGION_CLR_EN:   irq_en[idx]   = 1'b0;
                                    REGION_SET_PEND: irq_pend[idx] = 1'b1;
                                    default:         irq_pend[idx] = 1'b0;
                                endcase
                            end
                        end
                    end
                end
            end
            REGION_PRIO: begin
                lanes = (a.size == SIZE_BYTE) ? 1 : (a.size == SIZE_WORD) ? PRIO_LANES : 0;
                if (lanes == 0) begin
                    r.status = ST_BAD_SIZE;
                end else begin
                    bits = (prio_bits_cfg < PRIO_BITS_MIN) ? PRIO_BITS_MIN :
                           (prio_bits_cfg > PRIO_BITS_MAX) ? PRIO_BITS_MAX : prio_bits_cfg;
                    mask = 8'hFF << (PRIO_BITS_MAX - bits);
                    for (int k = 0; k < lanes; k++) begin
                        idx = a.offset - OFF_PRIO_FIRST + k;
                        if (idx < IRQ_COUNT) begin
                            if (a.op == OP_WRITE) begin
                                irq_prio[idx] = a.data[8*k +: 8] & mask;
                            end else begin
                                rd[8*k +: 8] = irq_prio[idx];
                            end
                        end
                    end
                end
            end
            default: begin
                r.status = ST_UNHANDLED;
            end
        endcase
        r.read_data = (a.op == OP_WRITE || r.status != ST_OK) ? '0 : rd;
        return r;
    endfunction

    function automatic bus_access_t random_access();
        bus_access_t a;
        int unsigned pick;
        pick   = $urandom_range(99);
        a.op   = 1'($urandom_range(1));
        a.data = ($urandom_range(3) == 0) ? (32'h1 << $urandom_range(31)) : $urandom;
        a.size = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : SIZE_WORD;
        if (pick < 35) begin
            case ($urandom_range(3))
                0:       a.offset = OFF_SET_EN;
                1:       a.offset = OFF_CLR_EN;
                2:       a.offset = OFF_SET_PEND;
                default: a.offset = OFF_CLR_PEND;
            endcase
            a.offset = a.offset + OFFSET_W'($urandom_range(WORD_SPAN - 1));
        end else if (pick < 75) begin
            case ($urandom_range(9))
                0:                a.size = 2'($urandom_range(3));
                1, 2, 3, 4:       a.size = SIZE_BYTE;
                default:          a.size = SIZE_WORD;
            endcase
            if ($urandom_range(3) == 0) begin
                a.offset = OFF_PRIO_FIRST +
                           OFFSET_W'($urandom_range(OFF_PRIO_END - OFF_PRIO_FIRST - 1));
            end else begin
                a.offset = OFF_PRIO_FIRST + OFFSET_W'($urandom_range(IRQ_COUNT + 3));
            end
        end else begin
            a.size   = 2'($urandom_range(3));
            a.offset = OFFSET_W'($urandom);
        end
        return a;
    endfunction

    task automatic enqueue(bus_access_t a);
        access_q.push_back(a);
        outstanding++;
    endtask

    task automatic wait_drained();
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic program_prio_bits(logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        prio_bits_cfg = value;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                response_q.push_back(apply_register_access(beat_on_bus));
            end
            if (!s_valid || s_ready) begin
                if (access_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    beat_on_bus = access_q.pop_front();
                    s_op          <= beat_on_bus.op;
                    s_access_size <= beat_on_bus.size;
                    s_reg_offset  <= beat_on_bus.offset;
                    s_write_data  <= beat_on_bus.data;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (response_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected response beat: read_data=%h status=%0d",
                                 m_read_data, m_status);
                    end
                end else begin
                    head_resp = response_q.pop_front();
                    outstanding--;
                    if (m_read_data !== head_resp.read_data
                        || m_status !== head_resp.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"response mismatch: expected read_data=%h status=%0d,",
                                      " got read_data=%h status=%0d"},
                                     head_resp.read_data, head_resp.status,
                                     m_read_data, m_status);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] cfg_plan[PHASES];
        cfg_plan = '{4'd0, 4'd8, 4'd15, 4'd3, 4'($urandom_range(15)), 4'd6};
        tx_idle_pct = 33;
        rx_idle_pct = 65;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_SET_EN,             32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_SET_EN,             32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_SET_EN + 12'h004,   32'h8000_0001});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_CLR_EN + 12'h004,   32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_CLR_EN,             32'h5555_5555});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_SET_EN + 12'h003,   32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_SET_EN + 12'h008,   32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_SET_EN + 12'h03C,   32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_SET_PEND + 12'h004, 32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_CLR_PEND + 12'h004, 32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_CLR_PEND + 12'h007, 32'hF0F0_F0F0});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_SET_PEND + 12'h03F, 32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_HALF, OFF_SET_EN,             32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_READ,  SIZE_RSVD, OFF_SET_PEND,           32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_BYTE, OFF_CLR_EN,             32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_WRITE, SIZE_BYTE, OFF_PRIO_FIRST,         32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_PRIO_FIRST + 12'h03D, 32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_PRIO_FIRST + 12'h03C, 32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_WORD, OFF_PRIO_FIRST + 12'h001, 32'h1234_ABCD});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_PRIO_FIRST,         32'h0});
        enqueue(bus_access_t'{OP_READ,  SIZE_HALF, OFF_PRIO_FIRST,         32'h0});
        enqueue(bus_access_t'{OP_READ,  SIZE_BYTE, OFF_PRIO_END - 12'h001, 32'h0});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_PRIO_END,           32'h0});
        enqueue(bus_access_t'{OP_WRITE, SIZE_RSVD, 12'hFFF,                32'hFFFF_FFFF});
        enqueue(bus_access_t'{OP_READ,  SIZE_WORD, OFF_SET_EN + WORD_SPAN, 32'h0});
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 2) begin
                tx_idle_pct = 65;
                rx_idle_pct = 33;
            end else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_prio_bits(cfg_plan[p]);
            repeat (PHASE_LEN) enqueue(random_access());
            wait_drained();
        end

        repeat (6) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
